// ----- design/vector_cpu_instruction_variant_decoder_unit_assert.svh -----
// Assertion macros for the variant decoder.
`ifndef VECTOR_CPU_INSTRUCTION_VARIANT_DECODER_UNIT_ASSERT_SVH
`define VECTOR_CPU_INSTRUCTION_VARIANT_DECODER_UNIT_ASSERT_SVH

// Clocked property, disabled while reset is high.
`define VCIVD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property that also holds during reset.
`define VCIVD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/vcivd_pkg.sv -----
package vcivd_pkg;

  localparam int unsigned PARCEL_W  = 16;
  localparam int unsigned VARIANT_W = 9;
  localparam int unsigned OPCODE_W  = 7;
  localparam int unsigned FIELD_W   = 3;
  localparam int unsigned OFFSET_W  = 5;

  localparam logic [VARIANT_W-1:0] VARIANT_MAX = 9'd298;
  localparam logic [2:0] LEN_ONE_PARCEL = 3'd2;
  localparam logic [2:0] LEN_TWO_PARCEL = 3'd4;

  typedef logic [VARIANT_W-1:0] variant_t;
  typedef logic [OPCODE_W-1:0]  opcode_t;
  typedef logic [FIELD_W-1:0]   field_t;
  typedef logic [PARCEL_W-1:0]  parcel_t;
  typedef logic [OFFSET_W-1:0]  offset_t;

  typedef struct packed {
    opcode_t op;
    field_t  i;
    field_t  j;
    field_t  k;
    logic    extra;
    parcel_t other;
  } fields_t;

  // Sub-decode group base per opcode; zero means the opcode is the variant.
  localparam variant_t GROUP_BASE [128] = '{
    9'o000, 9'o200, 9'o222, 9'o233, 9'o000, 9'o000, 9'o000, 9'o000,
    9'o240, 9'o242, 9'o244, 9'o246, 9'o250, 9'o252, 9'o254, 9'o256,
    9'o000, 9'o000, 9'o000, 9'o260, 9'o000, 9'o000, 9'o262, 9'o265,
    9'o267, 9'o272, 9'o000, 9'o276, 9'o000, 9'o000, 9'o000, 9'o000,
    9'o000, 9'o000, 9'o301, 9'o304, 9'o306, 9'o311, 9'o313, 9'o316,
    9'o323, 9'o325, 9'o000, 9'o000, 9'o000, 9'o000, 9'o332, 9'o335,
    9'o000, 9'o340, 9'o342, 9'o344, 9'o000, 9'o000, 9'o000, 9'o000,
    9'o000, 9'o346, 9'o356, 9'o361, 9'o000, 9'o000, 9'o000, 9'o370,
    9'o372, 9'o372, 9'o372, 9'o372, 9'o372, 9'o372, 9'o372, 9'o372,
    9'o375, 9'o375, 9'o375, 9'o375, 9'o375, 9'o375, 9'o375, 9'o375,
    9'o400, 9'o400, 9'o400, 9'o400, 9'o400, 9'o400, 9'o400, 9'o400,
    9'o403, 9'o403, 9'o403, 9'o403, 9'o403, 9'o403, 9'o403, 9'o403,
    9'o000, 9'o000, 9'o406, 9'o000, 9'o000, 9'o410, 9'o412, 9'o000,
    9'o414, 9'o416, 9'o420, 9'o422, 9'o000, 9'o000, 9'o424, 9'o000,
    9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000,
    9'o426, 9'o000, 9'o430, 9'o000, 9'o432, 9'o435, 9'o445, 9'o450
  };

  function automatic logic is_two_parcel(opcode_t op);
    return (op == 7'o006) || (op == 7'o007) ||
           ((op >= 7'o010) && (op <= 7'o021)) ||
           (op == 7'o040) || (op == 7'o041) ||
           ((op >= 7'o100) && (op <= 7'o137));
  endfunction

endpackage

// ----- design/vector_cpu_instruction_variant_decoder_unit.sv -----
// Channel   Handshake                     Payload
// parcel    parcel_valid / parcel_ready   first_parcel, second_parcel
// result    result_valid / result_ready   variant_index .. operand_word
//
// Three register stages: field split and group table lookup, rule offset,
// base add into the output register. One transaction per cycle sustained
// while result_ready holds. Reset clears the stage valid bits only. A stall
// on the result side backs up stage by stage; each stage refills as soon as
// the one after it moves, so nothing is dropped or repeated.
`include "vector_cpu_instruction_variant_decoder_unit_assert.svh"

module vector_cpu_instruction_variant_decoder_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               parcel_valid,
  output logic                               parcel_ready,
  input  logic [vcivd_pkg::PARCEL_W-1:0]     first_parcel,
  input  logic [vcivd_pkg::PARCEL_W-1:0]     second_parcel,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [vcivd_pkg::VARIANT_W-1:0]    variant_index,
  output logic                               extra_parcels,
  output logic [2:0]                         length_units,
  output logic [vcivd_pkg::OPCODE_W-1:0]     opcode_field,
  output logic [vcivd_pkg::FIELD_W-1:0]      h_field,
  output logic [vcivd_pkg::FIELD_W-1:0]      i_field,
  output logic [vcivd_pkg::FIELD_W-1:0]      j_field,
  output logic [vcivd_pkg::FIELD_W-1:0]      k_field,
  output logic [vcivd_pkg::PARCEL_W-1:0]     operand_word
);

  function automatic vcivd_pkg::offset_t rule_offset(
    vcivd_pkg::variant_t b, vcivd_pkg::field_t h, vcivd_pkg::field_t i,
    vcivd_pkg::field_t j, vcivd_pkg::field_t k, logic other_zero);
    vcivd_pkg::offset_t jo;
    vcivd_pkg::offset_t ko;
    vcivd_pkg::offset_t io;
    vcivd_pkg::offset_t r;
    jo = {2'b00, j};
    ko = {2'b00, k};
    io = {2'b00, i};
    r  = '0;
    case (b)
      9'o200: begin
        case (i)
          3'd1: r = 5'd1;
          3'd2: r = (k == 3'd0) ? 5'd2 : 5'd3;
          3'd3: r = 5'd4;
          3'd4: begin
            if (k == 3'd0) r = (j == 3'd2) ? 5'd7 : 5'd5;
            else if (k == 3'd1) r = 5'd6;
            else if (k inside {[3'd3:3'd7]}) r = 5'd5 + ko;
          end
          3'd5: r = (k == 3'd0) ? 5'd13 : 5'd14 + jo;
          default: r = '0;
        endcase
      end
      9'o222: r = (k != 3'd0) ? 5'd0 : 5'd1 + io;
      9'o233: begin
        case (i)
          3'd0: r = (j != 3'd0) ? 5'd0 : 5'd1;
          3'd4: r = 5'd2;
          3'd6: r = 5'd3;
          3'd7: r = 5'd4;
          default: r = '0;
        endcase
      end
      9'o240, 9'o242, 9'o244, 9'o246, 9'o250, 9'o252, 9'o254, 9'o256:
        r = {4'd0, i[2]};
      9'o260: r = (k == 3'd1) ? 5'd1 : 5'd0;
      9'o262: begin
        if (k == 3'd1) r = 5'd1;
        else if (k == 3'd7) r = 5'd2;
      end
      9'o265: r = (k == 3'd7) ? 5'd1 : 5'd0;
      9'o267: r = ((j == 3'd0) ? 5'd1 : 5'd0) + ((k == 3'd0) ? 5'd2 : 5'd0);
      9'o332, 9'o335:
        r = ((j == 3'd0) ? 5'd2 : 5'd0) + ((k == 3'd0) ? 5'd1 : 5'd0);
      9'o272: begin
        if (j == 3'd0) r = (k == 3'd0) ? 5'd1 : 5'd2;
        else r = (k == 3'd0) ? 5'd3 : 5'd0;
      end
      9'o276: begin
        if (j != 3'd0) r = (k == 3'd0) ? 5'd1 : 5'd2;
      end
      9'o301: begin
        if ((j == 3'd0) && (k == 3'd0)) r = 5'd2;
        else if ((j == 3'd7) && (k == 3'd7)) r = 5'd1;
      end
      9'o304: r = ((j == 3'd0) && (k == 3'd0)) ? 5'd1 : 5'd0;
      9'o306, 9'o313: begin
        if (k == 3'd0) r = (j == 3'd0) ? 5'd1 : 5'd2;
      end
      9'o311, 9'o323, 9'o414, 9'o416, 9'o420, 9'o422:
        r = (k == 3'd0) ? 5'd1 : 5'd0;
      9'o316, 9'o325: begin
        if (k == 3'd0) r = (j == 3'd0) ? 5'd4 : 5'd3;
        else r = (j == 3'd0) ? 5'd1 : 5'd0;
      end
      9'o340, 9'o342, 9'o344, 9'o370, 9'o406, 9'o412, 9'o424, 9'o426, 9'o430:
        r = (j == 3'd0) ? 5'd1 : 5'd0;
      9'o346: r = jo;
      9'o356: begin
        if (k == 3'd2) r = 5'd1;
        else if (k == 3'd3) r = 5'd2;
      end
      9'o361: begin
        if (k == 3'd1) r = 5'd1 + jo;
        else if (k == 3'd2) r = 5'd5;
        else if (k == 3'd3) r = 5'd6;
      end
      9'o372, 9'o375, 9'o400, 9'o403: begin
        if (h == 3'd0) r = 5'd1;
        else if ((j == 3'd0) && (k == 3'd0) && other_zero) r = 5'd2;
      end
      9'o410: r = (j == k) ? 5'd1 : 5'd0;
      9'o432, 9'o435: r = ko;
      9'o445: begin
        if (j == 3'd1) r = 5'd2;
        else r = (k == 3'd0) ? 5'd1 : 5'd0;
      end
      9'o450: begin
        if (i == 3'd1) r = 5'd2;
        else r = (k == 3'd0) ? 5'd1 : 5'd0;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  logic ready1;
  logic ready2;
  logic ready3;

  logic                v1;
  vcivd_pkg::fields_t  f1;
  vcivd_pkg::variant_t base1;

  logic                v2;
  vcivd_pkg::fields_t  f2;
  vcivd_pkg::variant_t base2;
  vcivd_pkg::offset_t  off2;

  logic                v3;
  vcivd_pkg::fields_t  f3;
  vcivd_pkg::variant_t variant3;

  vcivd_pkg::fields_t  f1_next;
  vcivd_pkg::variant_t variant3_next;

  assign ready3 = !v3 || result_ready;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;
  assign parcel_ready = ready1;

  always_comb begin
    f1_next.op    = first_parcel[15:9];
    f1_next.i     = first_parcel[8:6];
    f1_next.j     = first_parcel[5:3];
    f1_next.k     = first_parcel[2:0];
    f1_next.extra = vcivd_pkg::is_two_parcel(first_parcel[15:9]);
    f1_next.other = f1_next.extra ? second_parcel : '0;
  end

  always_comb begin
    if (base2 == '0) begin
      variant3_next = {2'b00, f2.op};
    end else begin
      variant3_next = base2 + {4'd0, off2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= parcel_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && parcel_valid) begin
      f1    <= f1_next;
      base1 <= vcivd_pkg::GROUP_BASE[first_parcel[15:9]];
    end
    if (ready2 && v1) begin
      f2    <= f1;
      base2 <= base1;
      off2  <= rule_offset(base1, f1.op[2:0], f1.i, f1.j, f1.k, f1.other == '0);
    end
    if (ready3 && v2) begin
      f3       <= f2;
      variant3 <= variant3_next;
    end
  end

  assign result_valid  = v3;
  assign variant_index = variant3;
  assign extra_parcels = f3.extra;
  assign length_units  = f3.extra ? vcivd_pkg::LEN_TWO_PARCEL : vcivd_pkg::LEN_ONE_PARCEL;
  assign opcode_field  = f3.op;
  assign h_field       = f3.op[2:0];
  assign i_field       = f3.i;
  assign j_field       = f3.j;
  assign k_field       = f3.k;
  assign operand_word  = f3.other;

  `VCIVD_ASSERT(a_accept_fills, parcel_valid && parcel_ready |=> v1, "accepted transaction lost")
  `VCIVD_ASSERT(a_variant_range, result_valid |-> variant_index <= vcivd_pkg::VARIANT_MAX, "variant out of range")
  `VCIVD_ASSERT(a_one_parcel_operand, result_valid && !extra_parcels |-> operand_word == '0, "operand on one-parcel op")
  `VCIVD_ASSERT(a_stall_holds, v3 && !result_ready |=> v3 && $stable(variant3), "stalled result changed")
  `VCIVD_ASSERT_ALWAYS(a_reset_empty, rst |=> !v1 && !v2 && !v3, "pipeline not empty after reset")

endmodule
